FILE: src/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform core.
// Used by hpt_mac, hpt_div and homogeneous_point_transform_core.
package hpt_pkg;

    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COEF_COUNT = 16;
    localparam int COEF_IDX_W = 4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    // Matrix row that holds the translation, column that gives w.
    localparam logic [1:0] TRANS_ROW = 2'd3;
    localparam logic [1:0] W_COL     = 2'd3;
    localparam logic [1:0] LAST_XYZ  = 2'd2;

    // Sub-steps of one column of multiply-accumulate work.
    localparam logic [3:0] MAC_INIT       = 4'd0;
    localparam logic [3:0] MAC_FIRST      = 4'd1;
    localparam logic [3:0] MAC_LAST_ISSUE = 4'd6;
    localparam logic [3:0] MAC_STORE      = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
        logic hi;
    } t_mac_ctl;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

FILE: src/homogeneous_point_transform_core.sv
// Homogeneous 4x4 point transform with perspective divide, signed fixed point.
// Depends on hpt_pkg, hpt_mac and hpt_div.
//
// A load transaction writes one coefficient. A transform transaction runs on
// the shared multiply-accumulate unit (four columns of nine steps: translation
// load, six half-width partial products, drain, store), then handles x, y and z
// one at a time on the shared restoring divider; a quotient known to overflow
// ends its division early, and a zero w skips the divider. The input is stalled
// for the whole transform. The result sits in an output register, so the next
// transaction is taken while it waits to be collected.
module homogeneous_point_transform_core #(
    parameter int VALUE_WIDTH   = hpt_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = hpt_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [hpt_pkg::COEF_IDX_W-1:0] i_coef_index,
    input  logic signed [VALUE_WIDTH-1:0] i_coef_value,
    input  logic signed [VALUE_WIDTH-1:0] i_point_x,
    input  logic signed [VALUE_WIDTH-1:0] i_point_y,
    input  logic signed [VALUE_WIDTH-1:0] i_point_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_result_x,
    output logic signed [VALUE_WIDTH-1:0] o_result_y,
    output logic signed [VALUE_WIDTH-1:0] o_result_z,
    output logic                          o_w_was_zero,
    output logic                          o_saturated
);

    localparam int VW    = VALUE_WIDTH;
    localparam int ACC_W = 2 * VW + 2;
    localparam int NUM_W = ACC_W + FRACTION_BITS;

    localparam logic [VW-1:0] MAX_VAL = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] MIN_VAL = {1'b1, {(VW - 1){1'b0}}};

    hpt_pkg::t_state    r_state, n_state;
    logic [1:0]         r_col, n_col;
    logic [3:0]         r_sub, n_sub;

    logic signed [VW-1:0]    r_coef [0:hpt_pkg::COEF_COUNT-1];
    logic signed [VW-1:0]    r_pt   [0:2];
    logic signed [ACC_W-1:0] r_acc  [0:3];
    logic [VW-1:0]           r_res  [0:2];
    logic                    r_sat;
    logic                    r_wzero;

    logic                    r_out_vld;
    logic [VW-1:0]           r_out_x, r_out_y, r_out_z;
    logic                    r_out_wz, r_out_sat;

    logic                    w_in_acc;
    logic [3:0]              w_sub_m1;
    logic [1:0]              w_k;
    logic [1:0]              w_pt_idx;
    logic [hpt_pkg::COEF_IDX_W-1:0] w_rd_addr;
    hpt_pkg::t_mac_ctl       w_mac_ctl;
    logic signed [ACC_W-1:0] w_mac_acc;

    logic signed [ACC_W-1:0] w_acc_n, w_acc_w;
    logic                    w_neg_n, w_neg_w, w_wzero;
    logic [ACC_W-1:0]        w_mag_n, w_mag_w, w_shift;
    logic                    w_div_start;
    hpt_pkg::t_div_stat      w_div_stat;
    logic [VW-1:0]           w_div_quot;

    logic                    w_qbig, w_qneg;
    logic [VW-1:0]           w_qv;
    logic                    w_clip_sat;
    logic [VW-1:0]           w_clip_val;

    logic                    w_res_we;
    logic                    w_out_load;

    assign o_in_stall = (r_state != hpt_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_sub_m1  = r_sub - 4'd1;
    assign w_k       = w_sub_m1[2:1];
    assign w_pt_idx  = (w_k == 2'd3) ? 2'd0 : w_k;
    assign w_rd_addr = (r_sub == hpt_pkg::MAC_INIT) ? {hpt_pkg::TRANS_ROW, r_col} : {w_k, r_col};

    assign w_mac_ctl.load  = (r_state == hpt_pkg::ST_MAC) && (r_sub == hpt_pkg::MAC_INIT);
    assign w_mac_ctl.issue = (r_state == hpt_pkg::ST_MAC) && (r_sub >= hpt_pkg::MAC_FIRST)
                             && (r_sub <= hpt_pkg::MAC_LAST_ISSUE);
    assign w_mac_ctl.hi    = w_sub_m1[0];

    hpt_mac #(
        .VW    (VW),
        .FB    (FRACTION_BITS),
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (r_coef[w_rd_addr]),
        .i_pt    (r_pt[w_pt_idx]),
        .o_acc   (w_mac_acc)
    );

    assign w_acc_n = r_acc[r_col];
    assign w_acc_w = r_acc[hpt_pkg::W_COL];
    assign w_neg_n = w_acc_n[ACC_W-1];
    assign w_neg_w = w_acc_w[ACC_W-1];
    assign w_mag_n = w_neg_n ? ACC_W'(-w_acc_n) : ACC_W'(w_acc_n);
    assign w_mag_w = w_neg_w ? ACC_W'(-w_acc_w) : ACC_W'(w_acc_w);
    assign w_wzero = (w_acc_w == '0);
    assign w_shift = w_mag_n >> FRACTION_BITS;

    hpt_div #(
        .VW    (VW),
        .ACC_W (ACC_W),
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_mag_n, {FRACTION_BITS{1'b0}}}),
        .i_den   (w_mag_w),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot)
    );

    always_comb begin
        if (r_state == hpt_pkg::ST_DIV_WAIT) begin
            w_qbig = w_div_stat.ovf;
            w_qv   = w_div_quot;
            w_qneg = w_neg_n ^ w_neg_w;
        end else begin
            w_qbig = |w_shift[ACC_W-1:VW];
            w_qv   = w_shift[VW-1:0];
            w_qneg = w_neg_n;
        end
        if (w_qneg) begin
            w_clip_sat = w_qbig || (w_qv[VW-1] && (|w_qv[VW-2:0]));
            w_clip_val = w_clip_sat ? MIN_VAL : ((~w_qv) + VW'(1));
        end else begin
            w_clip_sat = w_qbig || w_qv[VW-1];
            w_clip_val = w_clip_sat ? MAX_VAL : w_qv;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_sub       = r_sub;
        w_div_start = 1'b0;
        w_res_we    = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            hpt_pkg::ST_IDLE: begin
                if (w_in_acc && (i_mode == hpt_pkg::MODE_XFORM)) begin
                    n_state = hpt_pkg::ST_MAC;
                    n_col   = 2'd0;
                    n_sub   = hpt_pkg::MAC_INIT;
                end
            end
            hpt_pkg::ST_MAC: begin
                if (r_sub == hpt_pkg::MAC_STORE) begin
                    n_sub = hpt_pkg::MAC_INIT;
                    if (r_col == hpt_pkg::W_COL) begin
                        n_col   = 2'd0;
                        n_state = hpt_pkg::ST_DIV_START;
                    end else begin
                        n_col = r_col + 2'd1;
                    end
                end else begin
                    n_sub = r_sub + 4'd1;
                end
            end
            hpt_pkg::ST_DIV_START: begin
                if (w_wzero) begin
                    w_res_we = 1'b1;
                    if (r_col == hpt_pkg::LAST_XYZ) begin
                        n_state = hpt_pkg::ST_OUT;
                    end else begin
                        n_col = r_col + 2'd1;
                    end
                end else begin
                    w_div_start = 1'b1;
                    n_state     = hpt_pkg::ST_DIV_WAIT;
                end
            end
            hpt_pkg::ST_DIV_WAIT: begin
                if (w_div_stat.done) begin
                    w_res_we = 1'b1;
                    if (r_col == hpt_pkg::LAST_XYZ) begin
                        n_state = hpt_pkg::ST_OUT;
                    end else begin
                        n_col   = r_col + 2'd1;
                        n_state = hpt_pkg::ST_DIV_START;
                    end
                end
            end
            hpt_pkg::ST_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = hpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hpt_pkg::ST_IDLE;
            r_col     <= 2'd0;
            r_sub     <= hpt_pkg::MAC_INIT;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_sub   <= n_sub;
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (i_mode == hpt_pkg::MODE_LOAD) begin
                r_coef[i_coef_index] <= i_coef_value;
            end else begin
                r_pt[0] <= i_point_x;
                r_pt[1] <= i_point_y;
                r_pt[2] <= i_point_z;
                r_sat   <= 1'b0;
            end
        end
        if ((r_state == hpt_pkg::ST_MAC) && (r_sub == hpt_pkg::MAC_STORE)) begin
            r_acc[r_col] <= w_mac_acc;
        end
        if (w_res_we) begin
            r_res[r_col] <= w_clip_val;
            r_sat        <= r_sat | w_clip_sat;
            r_wzero      <= w_wzero;
        end
        if (w_out_load) begin
            r_out_x   <= r_res[0];
            r_out_y   <= r_res[1];
            r_out_z   <= r_res[2];
            r_out_wz  <= r_wzero;
            r_out_sat <= r_sat;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_result_x   = r_out_x;
    assign o_result_y   = r_out_y;
    assign o_result_z   = r_out_z;
    assign o_w_was_zero = r_out_wz;
    assign o_saturated  = r_out_sat;

endmodule

FILE: src/hpt_mac.sv
// Shared multiply-accumulate unit: one half-width partial product per cycle.
// Depends on hpt_pkg for the control struct.
module hpt_mac #(
    parameter int VW    = hpt_pkg::VALUE_WIDTH_DEF,
    parameter int FB    = hpt_pkg::FRACTION_BITS_DEF,
    parameter int ACC_W = 2 * VW + 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  hpt_pkg::t_mac_ctl       i_ctl,
    input  logic signed [VW-1:0]    i_coef,
    input  logic signed [VW-1:0]    i_pt,
    output logic signed [ACC_W-1:0] o_acc
);

    localparam int LO_W = VW / 2;
    localparam int B_W  = LO_W + 1;
    localparam int P_W  = VW + B_W;

    logic signed [B_W-1:0]   w_b;
    logic signed [P_W-1:0]   w_prod;
    logic signed [ACC_W-1:0] w_term;

    logic signed [P_W-1:0]   r_prod;
    logic                    r_phi;
    logic                    r_pvld;
    logic signed [ACC_W-1:0] r_acc;

    assign w_b    = i_ctl.hi ? B_W'($signed(i_coef[VW-1:LO_W]))
                             : $signed({1'b0, i_coef[LO_W-1:0]});
    assign w_prod = i_pt * w_b;
    assign w_term = r_phi ? (ACC_W'(r_prod) <<< LO_W) : ACC_W'(r_prod);
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        r_phi  <= i_ctl.hi;
        if (i_ctl.load) begin
            r_acc <= ACC_W'(i_coef) <<< FB;
        end else if (r_pvld) begin
            r_acc <= r_acc + w_term;
        end
    end

endmodule

FILE: src/hpt_div.sv
// Restoring divider, one quotient bit per cycle, with early overflow detect.
// Depends on hpt_pkg for the status struct.
module hpt_div #(
    parameter int VW    = hpt_pkg::VALUE_WIDTH_DEF,
    parameter int ACC_W = 2 * VW + 2,
    parameter int NUM_W = ACC_W + hpt_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [ACC_W-1:0]   i_den,
    output hpt_pkg::t_div_stat o_stat,
    output logic [VW-1:0]      o_quot
);

    localparam int HI_W  = NUM_W - VW;
    localparam int CNT_W = $clog2(VW + 1);

    logic [HI_W-1:0]  w_hi;
    logic             w_hi_ge;
    logic [ACC_W:0]   w_trial;
    logic [ACC_W:0]   w_diff;
    logic             w_fit;
    logic             w_done;

    logic [ACC_W-1:0] r_rem;
    logic [ACC_W-1:0] r_den;
    logic [VW-1:0]    r_low;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_ovf;

    assign w_hi    = i_num[NUM_W-1:VW];
    assign w_hi_ge = NUM_W'(w_hi) >= NUM_W'(i_den);
    assign w_trial = {r_rem, r_low[VW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = !w_diff[ACC_W];
    assign w_done  = r_busy && (r_ovf || (r_cnt == '0));

    assign o_stat.done = w_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quot      = r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf <= w_hi_ge;
            r_rem <= ACC_W'(w_hi);
            r_den <= i_den;
            r_low <= i_num[VW-1:0];
            r_cnt <= CNT_W'(VW);
        end else if (r_busy && !w_done) begin
            r_rem <= w_fit ? w_diff[ACC_W-1:0] : w_trial[ACC_W-1:0];
            r_low <= {r_low[VW-2:0], w_fit};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule
